[sv/uart_rb_pkg.sv]
// ---------------------------------------------------------------------------
// UART ring buffer package
// Transfer payload types, opcodes and ring status shared by the ring buffer
// block and its ring submodule.
// ---------------------------------------------------------------------------
package uart_rb_pkg;

    // Opcodes carried by an input transfer
    localparam logic [1:0] OP_HOST_WR  = 2'd0;  // host write, push transmit ring
    localparam logic [1:0] OP_HOST_RD  = 2'd1;  // host read, pop receive ring
    localparam logic [1:0] OP_LINE_RX  = 2'd2;  // line byte, push receive ring
    localparam logic [1:0] OP_TX_READY = 2'd3;  // transmitter ready, pop transmit ring

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] byte_in;
    } t_in_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] byte_out;
        logic       tx_irq_enabled;
    } t_out_item;

    // Ring occupancy flags
    typedef struct packed {
        logic full;
        logic empty;
    } t_ring_stat;

endpackage

[sv/uart_rb_ring.sv]
// ---------------------------------------------------------------------------
// UART ring buffer - one byte ring
// Synchronous byte memory with write and read pointers; one slot is kept
// free. Read data is registered and holds until the next pop.
// ---------------------------------------------------------------------------
module uart_rb_ring #(
    parameter int DEPTH = 128
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  logic                    i_pop,
    input  logic [7:0]              i_wr_byte,
    output uart_rb_pkg::t_ring_stat o_stat,
    output logic [7:0]              o_rd_byte
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [AW-1:0] wr_next;
    logic [AW-1:0] rd_next;
    logic [7:0]    r_rd_byte;

    assign wr_next = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + AW'(1);
    assign rd_next = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + AW'(1);

    assign o_stat.full  = (wr_next == r_rd_ptr);
    assign o_stat.empty = (r_wr_ptr == r_rd_ptr);

    always_comb begin
        n_wr_ptr = i_push ? wr_next : r_wr_ptr;
        n_rd_ptr = i_pop  ? rd_next : r_rd_ptr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
        end
    end

    // Byte storage: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            mem[r_wr_ptr] <= i_wr_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_pop) begin
            r_rd_byte <= mem[r_rd_ptr];
        end
    end

    assign o_rd_byte = r_rd_byte;

endmodule

[sv/uart_rx_tx_ring_buffers.sv]
// ---------------------------------------------------------------------------
// UART receive / transmit ring buffers
// Two byte rings (receive and transmit) with host and line side opcodes and a
// transmit interrupt enable flag.
// ---------------------------------------------------------------------------
//
//  Channel | Direction | Handshake                | Payload
//  --------+-----------+--------------------------+---------------------------
//  in      | input     | i_in_valid / o_in_ready  | i_in_item  (opcode, byte)
//  out     | output    | o_out_valid / i_out_ready| o_out_item (ok, byte, irq)
//
//  One transfer per cycle sustained while the output is not stalled; an
//  item's result passes the ring memory read and then the output register
//  before it leaves.
//  Pointers and the interrupt flag update at the input transfer; the memory
//  read data is registered then too and merged in by the read stage.
//  Synchronous active-low reset clears pointers, flag and valid bits; the ring
//  memories are not cleared (a pop never reads an unwritten entry).
//  A stalled output holds one result; one more item is taken into the
//  read stage, after which input ready drops until the output drains.
// ---------------------------------------------------------------------------
module uart_rx_tx_ring_buffers #(
    parameter int RX_DEPTH = 128,
    parameter int TX_DEPTH = 128
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_ready,
    input  uart_rb_pkg::t_in_item  i_in_item,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output uart_rb_pkg::t_out_item o_out_item
);

    uart_rb_pkg::t_ring_stat rx_stat;
    uart_rb_pkg::t_ring_stat tx_stat;
    logic [7:0]              rx_rd_byte;
    logic [7:0]              tx_rd_byte;

    logic in_xfer;
    logic rx_push, rx_pop, tx_push, tx_pop;
    logic op_ok;

    // Interrupt enable
    logic r_irq, n_irq;

    // Read stage: waits on the memory read data
    logic r_s1_valid;
    logic r_s1_ok;
    logic r_s1_from_rx;
    logic r_s1_from_tx;
    logic r_s1_irq;
    logic s1_move;
    uart_rb_pkg::t_out_item s1_item;

    // Output register
    logic                   r_out_valid;
    uart_rb_pkg::t_out_item r_out_item;

    // A transfer is taken when the read stage is empty or moving on
    assign s1_move    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_move;
    assign in_xfer    = i_in_valid && o_in_ready;

    // Full / empty gating per opcode
    assign tx_push = in_xfer && (i_in_item.opcode == uart_rb_pkg::OP_HOST_WR)
                     && !tx_stat.full;
    assign rx_pop  = in_xfer && (i_in_item.opcode == uart_rb_pkg::OP_HOST_RD)
                     && !rx_stat.empty;
    assign rx_push = in_xfer && (i_in_item.opcode == uart_rb_pkg::OP_LINE_RX)
                     && !rx_stat.full;
    assign tx_pop  = in_xfer && (i_in_item.opcode == uart_rb_pkg::OP_TX_READY)
                     && !tx_stat.empty;
    assign op_ok   = tx_push || rx_pop || rx_push || tx_pop;

    // Host write that pushes sets the enable; transmitter ready on empty clears it
    always_comb begin
        n_irq = r_irq;
        if (tx_push) begin
            n_irq = 1'b1;
        end else if (in_xfer && (i_in_item.opcode == uart_rb_pkg::OP_TX_READY)
                     && tx_stat.empty) begin
            n_irq = 1'b0;
        end
    end

    uart_rb_ring #(
        .DEPTH (RX_DEPTH)
    ) u_rx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (rx_push),
        .i_pop     (rx_pop),
        .i_wr_byte (i_in_item.byte_in),
        .o_stat    (rx_stat),
        .o_rd_byte (rx_rd_byte)
    );

    uart_rb_ring #(
        .DEPTH (TX_DEPTH)
    ) u_tx_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (tx_push),
        .i_pop     (tx_pop),
        .i_wr_byte (i_in_item.byte_in),
        .o_stat    (tx_stat),
        .o_rd_byte (tx_rd_byte)
    );

    // Result of the read stage; byte is zero unless a pop succeeded
    always_comb begin
        s1_item.ok             = r_s1_ok;
        s1_item.tx_irq_enabled = r_s1_irq;
        if (r_s1_from_rx) begin
            s1_item.byte_out = rx_rd_byte;
        end else if (r_s1_from_tx) begin
            s1_item.byte_out = tx_rd_byte;
        end else begin
            s1_item.byte_out = 8'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_irq       <= 1'b0;
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_irq <= n_irq;
            if (in_xfer) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_ok      <= op_ok;
            r_s1_from_rx <= rx_pop;
            r_s1_from_tx <= tx_pop;
            r_s1_irq     <= n_irq;
        end
        if (s1_move) begin
            r_out_item <= s1_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

[bench/tb_uart_rx_tx_ring_buffers.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Testbench for the UART receive / transmit ring buffers
// Drives opcode transfers through the valid/ready input channel, predicts
// every result with a behavioral copy of both rings and the interrupt flag,
// and checks each output transfer in order. A short directed table covers
// the empty cases and byte extremes; biased random traffic then fills and
// drains each ring to hit the full cases, under random idling on both sides
// and long output hold-offs that back the block up.
// ---------------------------------------------------------------------------
module tb_uart_rx_tx_ring_buffers;

    localparam int RX_DEPTH     = 128;
    localparam int TX_DEPTH     = 128;
    localparam int RANDOM_ITEMS = 1930;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;      // read stage and output register plus margin

    // Directed row: stimulus plus an optional typed-in expectation
    typedef struct packed {
        logic [1:0]             opcode;
        logic [7:0]             byte_in;
        logic                   typed;      // 1: use exp below, 0: use predictor
        uart_rb_pkg::t_out_item exp;
    } t_dir_row;

    // Traffic shapes of the random part
    typedef enum int {FILL_TX, FILL_RX, DRAIN_TX, DRAIN_RX, MIXED} t_traffic;

    localparam int DIR_ROWS = 22;
    localparam t_dir_row DIR_TABLE [DIR_ROWS] = '{
        // empty rings straight after reset
        '{uart_rb_pkg::OP_HOST_RD,  8'hA5, 1'b1, '{1'b0, 8'h00, 1'b0}},
        '{uart_rb_pkg::OP_TX_READY, 8'hFF, 1'b1, '{1'b0, 8'h00, 1'b0}},
        // transmit ring: byte extremes in and out, then empty clears irq
        '{uart_rb_pkg::OP_HOST_WR,  8'h00, 1'b1, '{1'b1, 8'h00, 1'b1}},
        '{uart_rb_pkg::OP_HOST_WR,  8'hFF, 1'b1, '{1'b1, 8'h00, 1'b1}},
        '{uart_rb_pkg::OP_TX_READY, 8'h33, 1'b1, '{1'b1, 8'h00, 1'b1}},
        '{uart_rb_pkg::OP_TX_READY, 8'h00, 1'b1, '{1'b1, 8'hFF, 1'b1}},
        '{uart_rb_pkg::OP_TX_READY, 8'hC3, 1'b1, '{1'b0, 8'h00, 1'b0}},
        // receive ring: byte extremes in and out, then read on empty
        '{uart_rb_pkg::OP_LINE_RX,  8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{uart_rb_pkg::OP_LINE_RX,  8'h00, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{uart_rb_pkg::OP_LINE_RX,  8'h5A, 1'b0, '0},
        '{uart_rb_pkg::OP_HOST_RD,  8'h00, 1'b1, '{1'b1, 8'hFF, 1'b0}},
        '{uart_rb_pkg::OP_HOST_RD,  8'hFF, 1'b1, '{1'b1, 8'h00, 1'b0}},
        '{uart_rb_pkg::OP_HOST_RD,  8'h81, 1'b0, '0},
        '{uart_rb_pkg::OP_HOST_RD,  8'h7E, 1'b1, '{1'b0, 8'h00, 1'b0}},
        // interleaved traffic on both rings
        '{uart_rb_pkg::OP_HOST_WR,  8'h81, 1'b0, '0},
        '{uart_rb_pkg::OP_LINE_RX,  8'h7E, 1'b0, '0},
        '{uart_rb_pkg::OP_HOST_WR,  8'h3C, 1'b0, '0},
        '{uart_rb_pkg::OP_TX_READY, 8'hAA, 1'b0, '0},
        '{uart_rb_pkg::OP_HOST_RD,  8'h55, 1'b0, '0},
        '{uart_rb_pkg::OP_TX_READY, 8'h01, 1'b0, '0},
        '{uart_rb_pkg::OP_TX_READY, 8'h80, 1'b1, '{1'b0, 8'h00, 1'b0}},
        '{uart_rb_pkg::OP_HOST_RD,  8'hFE, 1'b1, '{1'b0, 8'h00, 1'b0}}
    };

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_ready;
    uart_rb_pkg::t_in_item  i_in_item;
    logic                   o_out_valid;
    logic                   i_out_ready;
    uart_rb_pkg::t_out_item o_out_item;

    // Behavioral copy of the two rings and the transmit interrupt enable
    logic [7:0] rx_bytes [RX_DEPTH];
    logic [7:0] tx_bytes [TX_DEPTH];
    int         rx_wr_idx, rx_rd_idx;
    int         tx_wr_idx, tx_rd_idx;
    logic       tx_irq_en;

    uart_rb_pkg::t_out_item pending_replies [$];   // expected results, oldest first
    int                     fail_count;
    int                     burst_left;
    int                     cycle_count;

    uart_rx_tx_ring_buffers #(
        .RX_DEPTH (RX_DEPTH),
        .TX_DEPTH (TX_DEPTH)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Advance the ring copy by one opcode and return the result it gives.
    // A full push leaves everything alone, irq flag included; a transmitter
    // ready on an empty ring is the only thing that clears the irq flag.
    function automatic uart_rb_pkg::t_out_item uart_rings_next(
        input uart_rb_pkg::t_in_item item
    );
        uart_rb_pkg::t_out_item res;
        int                     nxt;
        res = '0;
        case (item.opcode)
            uart_rb_pkg::OP_HOST_WR: begin
                nxt = (tx_wr_idx + 1) % TX_DEPTH;
                if (nxt != tx_rd_idx) begin
                    tx_bytes[tx_wr_idx] = item.byte_in;
                    tx_wr_idx = nxt;
                    tx_irq_en = 1'b1;
                    res.ok = 1'b1;
                end
            end
            uart_rb_pkg::OP_HOST_RD: begin
                if (rx_rd_idx != rx_wr_idx) begin
                    res.byte_out = rx_bytes[rx_rd_idx];
                    rx_rd_idx = (rx_rd_idx + 1) % RX_DEPTH;
                    res.ok = 1'b1;
                end
            end
            uart_rb_pkg::OP_LINE_RX: begin
                nxt = (rx_wr_idx + 1) % RX_DEPTH;
                if (nxt != rx_rd_idx) begin
                    rx_bytes[rx_wr_idx] = item.byte_in;
                    rx_wr_idx = nxt;
                    res.ok = 1'b1;
                end
            end
            default: begin  // transmitter ready
                if (tx_rd_idx != tx_wr_idx) begin
                    res.byte_out = tx_bytes[tx_rd_idx];
                    tx_rd_idx = (tx_rd_idx + 1) % TX_DEPTH;
                    res.ok = 1'b1;
                end else begin
                    tx_irq_en = 1'b0;
                end
            end
        endcase
        res.tx_irq_enabled = tx_irq_en;
        return res;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
        fail_count++;
    endtask

    // Sender pacing: bursts of random length, then a random gap with valid
    // low. Some bursts are long so there are stretches with no idling.
    task automatic pace_sender();
        if (burst_left == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(80, 200)
                                                      : $urandom_range(1, 24);
        end
        burst_left--;
    endtask

    // Offer one item from a falling edge and hold it until the transfer.
    // The expectation is queued at the accepting edge; since the result still
    // passes the read stage and output register, it cannot leave at that edge.
    task automatic offer_item(input uart_rb_pkg::t_in_item item, input logic typed,
                              input uart_rb_pkg::t_out_item typed_exp);
        uart_rb_pkg::t_out_item predicted;
        i_in_valid <= 1'b1;
        i_in_item  <= item;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predicted = uart_rings_next(item);
        pending_replies.push_back(typed ? typed_exp : predicted);
        @(negedge i_clk);
    endtask

    // Output checker: every output transfer against the oldest expectation
    always @(posedge i_clk) begin
        uart_rb_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_replies.size() == 0) begin
                flag_mismatch("unexpected transfer", o_out_item, 0);
            end else begin
                want = pending_replies.pop_front();
                if (o_out_item.ok !== want.ok)
                    flag_mismatch("ok", o_out_item.ok, want.ok);
                if (o_out_item.byte_out !== want.byte_out)
                    flag_mismatch("byte_out", o_out_item.byte_out, want.byte_out);
                if (o_out_item.tx_irq_enabled !== want.tx_irq_enabled)
                    flag_mismatch("tx_irq_enabled", o_out_item.tx_irq_enabled,
                                  want.tx_irq_enabled);
            end
        end
    end

    // Receiver: ready follows a 16-bit stall pattern reloaded after each pass
    // through its bits (sometimes all ones), and now and then holds off for a
    // long stretch so the block fills and drops its input ready.
    initial begin
        logic [15:0] stall_pat;
        int          bit_idx;
        int          rx_cycle;
        int          hold_left;
        int          next_hold;
        i_out_ready = 1'b0;
        stall_pat   = '1;
        bit_idx     = 0;
        rx_cycle    = 0;
        hold_left   = 0;
        next_hold   = 300;
        forever begin
            @(negedge i_clk);
            rx_cycle++;
            if (rx_cycle == next_hold) begin
                hold_left = $urandom_range(40, 90);
                next_hold = rx_cycle + $urandom_range(1500, 2500);
            end
            if (bit_idx == 0)
                stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom);
            if (hold_left > 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= stall_pat[bit_idx];
            end
            bit_idx = (bit_idx + 1) % 16;
        end
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    // Main sequence: reset, directed table, random traffic, drain, verdict
    initial begin
        uart_rb_pkg::t_in_item item;
        t_traffic              mode;
        logic [1:0]            lead_op;
        int                    sent;
        int                    phase_idx;
        int                    run_len;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_item  = '0;
        fail_count = 0;
        burst_left = 0;
        rx_wr_idx  = 0;
        rx_rd_idx  = 0;
        tx_wr_idx  = 0;
        tx_rd_idx  = 0;
        tx_irq_en  = 1'b0;

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part
        for (int r = 0; r < DIR_ROWS; r++) begin
            pace_sender();
            item.opcode  = DIR_TABLE[r].opcode;
            item.byte_in = DIR_TABLE[r].byte_in;
            offer_item(item, DIR_TABLE[r].typed, DIR_TABLE[r].exp);
        end

        // Random part: fill and drain phases push each ring past full and
        // empty many times; a mixed phase shakes up the interleaving.
        sent      = 0;
        phase_idx = 0;
        while (sent < RANDOM_ITEMS) begin
            mode    = t_traffic'(phase_idx % 5);
            run_len = (mode == MIXED) ? $urandom_range(60, 160) : $urandom_range(150, 260);
            if (run_len > RANDOM_ITEMS - sent)
                run_len = RANDOM_ITEMS - sent;
            case (mode)
                FILL_TX:  lead_op = uart_rb_pkg::OP_HOST_WR;
                FILL_RX:  lead_op = uart_rb_pkg::OP_LINE_RX;
                DRAIN_TX: lead_op = uart_rb_pkg::OP_TX_READY;
                DRAIN_RX: lead_op = uart_rb_pkg::OP_HOST_RD;
                default:  lead_op = uart_rb_pkg::OP_HOST_WR;
            endcase
            repeat (run_len) begin
                pace_sender();
                if (mode == MIXED || $urandom_range(0, 9) == 0)
                    item.opcode = 2'($urandom_range(0, 3));
                else
                    item.opcode = lead_op;
                item.byte_in = 8'($urandom_range(0, 255));
                offer_item(item, 1'b0, '0);
                sent++;
            end
            phase_idx++;
        end
        i_in_valid <= 1'b0;

        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[files.f]
sv/uart_rb_pkg.sv
sv/uart_rb_ring.sv
sv/uart_rx_tx_ring_buffers.sv
bench/tb_uart_rx_tx_ring_buffers.sv
